// ----- rtl/core/drr_pkg.sv -----
// package: constants, types and text tables of the diagnostic responder
`default_nettype none
package drr_pkg;
  localparam int HEADER_BYTES    = 11;
  localparam int HDR_USED        = 6;
  localparam int SERIAL_BYTES    = 8;
  localparam int MAX_REQUEST_LEN = 4095;
  localparam int CNT_W           = 12;
  localparam int VID_LEN         = 17;
  localparam int VER_LEN         = 6;
  localparam int MAX_OUT         = 20;
  localparam int IDX_W           = 5;
  localparam int CFG_IDX_W       = 8;

  localparam logic [7:0] SID_SESSION  = 8'h10;
  localparam logic [7:0] SID_SECURITY = 8'h27;
  localparam logic [7:0] SID_READ_ID  = 8'h22;
  localparam logic [7:0] SID_WRITE_ID = 8'h2E;
  localparam logic [7:0] SID_FAULTS   = 8'h19;
  localparam logic [7:0] SID_ROUTINE  = 8'h31;
  localparam logic [7:0] SID_DOWNLOAD = 8'h34;
  localparam logic [7:0] SID_TRANSFER = 8'h36;
  localparam logic [7:0] SID_EXIT     = 8'h37;

  localparam logic [7:0] NRC_NOT_SUPP   = 8'h11;
  localparam logic [7:0] NRC_SUB_FUNC   = 8'h12;
  localparam logic [7:0] NRC_LENGTH     = 8'h13;
  localparam logic [7:0] NRC_CONDITIONS = 8'h22;
  localparam logic [7:0] NRC_RANGE      = 8'h31;
  localparam logic [7:0] NRC_DENIED     = 8'h33;
  localparam logic [7:0] NRC_BAD_KEY    = 8'h35;
  localparam logic [7:0] NEG_SID        = 8'h7F;

  localparam logic [15:0] DID_VID    = 16'hF190;
  localparam logic [15:0] DID_VER    = 16'hF187;
  localparam logic [15:0] DID_SERIAL = 16'hF18C;

  localparam logic [CFG_IDX_W-1:0] CFG_SEED = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK = 8'd1;
  localparam logic [31:0] SEED_RESET = 32'h12345678;
  localparam logic [31:0] MASK_RESET = 32'h55AA55AA;

  typedef logic [7:0] byte_t;

  // one complete request as handed from front to back
  typedef struct packed {
    byte_t [HDR_USED-1:0]     hdr;
    byte_t [SERIAL_BYTES-1:0] stage;
    logic  [CNT_W-1:0]        count;
  } cmd_t;

  typedef enum logic [1:0] {ST_IDLE, ST_DECODE, ST_EMIT} back_state_t;

  typedef enum logic [3:0] {
    K_NONE, K_NEG, K_SESS, K_SEED, K_UNLOCK, K_RD_VID, K_RD_VER, K_RD_SN,
    K_WR_OK, K_FAULT, K_ROUT, K_DL, K_XFER, K_EXIT
  } kind_t;

  typedef struct packed {
    logic [1:0] q_count;
    logic       q_full;
    logic       busy;
  } status_t;

  function automatic byte_t vid_char(input logic [IDX_W-1:0] i);
    byte_t r;
    unique case (i)
      5'd0: r = "W";  5'd1: r = "A";  5'd2: r = "U";  5'd3: r = "Z";
      5'd4: r = "Z";  5'd5: r = "Z";  5'd6: r = "1";  5'd7: r = "2";
      5'd8: r = "3";  5'd9: r = "4";  5'd10: r = "5"; 5'd11: r = "6";
      5'd12: r = "7"; 5'd13: r = "8"; 5'd14: r = "9"; 5'd15: r = "0";
      5'd16: r = "1";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic byte_t ver_char(input logic [IDX_W-1:0] i);
    byte_t r;
    unique case (i)
      5'd0: r = "V"; 5'd1: r = "1"; 5'd2: r = "."; 5'd3: r = "0";
      5'd4: r = "."; 5'd5: r = "0";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic byte_t serial_init(input int i);
    byte_t r;
    unique case (i)
      0: r = "S"; 1: r = "N"; 2: r = "1"; 3: r = "2";
      4: r = "3"; 5: r = "4"; 6: r = "5"; 7: r = "6";
      default: r = 8'h00;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

// ----- rtl/core/drr_if.sv -----
// stream and configuration channel interfaces
`default_nettype none
interface drr_req_if;
  logic       valid;
  logic       ready;
  logic [7:0] request_byte;
  logic       request_last;
  modport source (output valid, request_byte, request_last, input ready);
  modport sink   (input valid, request_byte, request_last, output ready);
endinterface

interface drr_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] response_byte;
  logic       response_last;
  modport source (output valid, response_byte, response_last, input ready);
  modport sink   (input valid, response_byte, response_last, output ready);
endinterface

interface drr_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/diagnostic_request_responder_unit.sv -----
// top level of the diagnostic request responder
//  channel | dir | fields                          | accepted when
//  req     | in  | request_byte[8], request_last   | req.valid && req.ready
//  rsp     | out | response_byte[8], response_last | rsp.valid && rsp.ready
//  cfg     | in  | index[8], data[32]              | cfg.valid (ready always high)
// A request word is taken each cycle while the two-entry request queue has room.
// After the last word, the back end fetches and decodes the request, then emits
// one word per cycle while rsp is ready, from its output register (0 to 20 words).
// Synchronous reset restores session, lock, seed and serial text at once.
// A stalled rsp channel holds the back end; the front keeps capturing until
// the queue fills.
`default_nettype none
module diagnostic_request_responder_unit (
  input  wire logic clk,
  input  wire logic rst,
  drr_req_if.sink   req,
  drr_rsp_if.source rsp,
  drr_cfg_if.sink   cfg
);
  import drr_pkg::*;

  cmd_t        push_cmd, head;
  logic        push, pop, nonempty;
  logic        q_full, busy;
  logic [1:0]  q_count;
  status_t     st;
  logic [31:0] seed_value, key_mask;

  assign cfg.ready = 1'b1;
  assign st = '{q_count: q_count, q_full: q_full, busy: busy};

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      seed_value <= SEED_RESET;
      key_mask   <= MASK_RESET;
    end else if (cfg.valid) begin
      if (cfg.index == CFG_SEED) seed_value <= cfg.data;
      if (cfg.index == CFG_MASK) key_mask   <= cfg.data;
    end
  end

  drr_front u_front (
    .clk, .rst, .req, .q_full, .push_cmd, .push
  );

  drr_queue u_queue (
    .clk, .rst, .push, .push_cmd, .pop, .head, .nonempty,
    .full(q_full), .count(q_count)
  );

  drr_back u_back (
    .clk, .rst, .head, .nonempty, .pop, .seed_value, .key_mask, .rsp, .busy
  );

  // checks
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    st.q_full |-> !req.ready) else $error("request taken with queue full");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    st.q_count != 2'd3) else $error("queue count out of range");
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !rsp.valid) else $error("response valid after reset");
  a_busy_out: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> st.busy) else $error("response shown while back end idle");
endmodule
`default_nettype wire

// ----- rtl/core/drr_front.sv -----
// front: captures request words and hands complete requests to the queue
`default_nettype none
module drr_front (
  input  wire logic         clk,
  input  wire logic         rst,
  drr_req_if.sink           req,
  input  wire logic         q_full,
  output drr_pkg::cmd_t     push_cmd,
  output logic              push
);
  import drr_pkg::*;

  logic [CNT_W-1:0]        count;
  byte_t [HDR_USED-1:0]     hdr;
  byte_t [SERIAL_BYTES-1:0] stage;
  cmd_t                     cmd_next;
  logic                     acc;

  assign req.ready = !q_full;
  assign acc       = req.valid && req.ready;
  assign push      = acc && req.request_last;
  assign push_cmd  = cmd_next;

  // capture this word into header and write staging
  always_comb begin
    cmd_next.hdr   = hdr;
    cmd_next.stage = stage;
    for (int i = 0; i < HDR_USED; i++) begin
      if (count == CNT_W'(i)) cmd_next.hdr[i] = req.request_byte;
    end
    for (int i = 0; i < SERIAL_BYTES; i++) begin
      if (count == CNT_W'(i + 3)) cmd_next.stage[i] = req.request_byte;
    end
    cmd_next.count = (count < CNT_W'(MAX_REQUEST_LEN)) ? count + 1'b1 : count;
  end

  always_ff @(posedge clk) begin
    if (rst || push) begin
      count <= '0;
      hdr   <= '0;
      stage <= '0;
    end else if (acc) begin
      count <= cmd_next.count;
      hdr   <= cmd_next.hdr;
      stage <= cmd_next.stage;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/core/drr_queue.sv -----
// two-entry queue of complete requests between front and back
`default_nettype none
module drr_queue (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire drr_pkg::cmd_t push_cmd,
  input  wire logic         pop,
  output drr_pkg::cmd_t     head,
  output logic              nonempty,
  output logic              full,
  output logic [1:0]        count
);
  import drr_pkg::*;

  cmd_t [1:0] slot;
  logic       wptr;
  logic       rptr;

  assign head     = slot[rptr];
  assign nonempty = (count != 2'd0);
  assign full     = (count == 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= !wptr;
      if (pop)  rptr <= !rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot[wptr] <= push_cmd;
  end
endmodule
`default_nettype wire

// ----- rtl/core/drr_back.sv -----
// back: serves one request, updates state and streams the response words
`default_nettype none
module drr_back (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire drr_pkg::cmd_t head,
  input  wire logic         nonempty,
  output logic              pop,
  input  wire logic [31:0]  seed_value,
  input  wire logic [31:0]  key_mask,
  drr_rsp_if.source         rsp,
  output logic              busy
);
  import drr_pkg::*;

  back_state_t state, state_next;
  cmd_t        cmd;
  logic [1:0]  session_mode;
  logic        unlocked_flag;
  logic [31:0] latched_seed;
  byte_t [SERIAL_BYTES-1:0] serial_store;

  kind_t             kind, kind_next;
  logic [IDX_W-1:0]  len, len_next;
  logic [IDX_W-1:0]  idx;
  byte_t             neg_sid, neg_sid_next, neg_code, neg_code_next;
  byte_t             b0, b1, b2, b3;
  logic [15:0]       did;
  logic [31:0]       key;
  logic [IDX_W-1:0]  sn_len;
  logic              sn_stop;
  logic              load;
  logic              out_free;
  byte_t             cur_byte;
  logic [IDX_W-1:0]  tix;

  assign b0  = cmd.hdr[0];
  assign b1  = cmd.hdr[1];
  assign b2  = cmd.hdr[2];
  assign b3  = cmd.hdr[3];
  assign did = {b1, b2};
  assign key = {b2, b3, cmd.hdr[4], cmd.hdr[5]};
  assign out_free = !rsp.valid || rsp.ready;
  assign busy = (state != ST_IDLE) || rsp.valid;

  // serial text length: up to the first zero byte
  always_comb begin
    sn_len  = '0;
    sn_stop = 1'b0;
    for (int i = 0; i < SERIAL_BYTES; i++) begin
      if (serial_store[i] == 8'h00) sn_stop = 1'b1;
      if (!sn_stop && i < VID_LEN) sn_len = IDX_W'(i + 1);
    end
  end

  // service decode
  always_comb begin
    kind_next     = K_NEG;
    len_next      = 5'd3;
    neg_sid_next  = b0;
    neg_code_next = NRC_NOT_SUPP;
    unique case (b0)
      SID_SESSION: begin
        if (cmd.count != CNT_W'(2)) neg_code_next = NRC_LENGTH;
        else if (b1 < 8'd1 || b1 > 8'd3) neg_code_next = NRC_SUB_FUNC;
        else begin kind_next = K_SESS; len_next = 5'd6; end
      end
      SID_SECURITY: begin
        if (b1 == 8'h01) begin kind_next = K_SEED; len_next = 5'd6; end
        else if (b1 == 8'h02) begin
          if ((latched_seed ^ key_mask) == key) begin
            kind_next = K_UNLOCK; len_next = 5'd2;
          end else neg_code_next = NRC_BAD_KEY;
        end else begin kind_next = K_NONE; len_next = 5'd0; end
      end
      SID_READ_ID: begin
        if (did == DID_VID) begin kind_next = K_RD_VID; len_next = 5'd3 + 5'(VID_LEN); end
        else if (did == DID_VER) begin
          kind_next = K_RD_VER; len_next = 5'd3 + 5'(VER_LEN);
        end else if (did == DID_SERIAL) begin
          kind_next = K_RD_SN; len_next = 5'd3 + sn_len;
        end else neg_code_next = NRC_RANGE;
      end
      SID_WRITE_ID: begin
        if (!unlocked_flag) neg_code_next = NRC_DENIED;
        else if (did != DID_SERIAL) neg_code_next = NRC_RANGE;
        else kind_next = K_WR_OK;
      end
      SID_FAULTS: begin
        if (b1 != 8'h02) neg_code_next = NRC_SUB_FUNC;
        else begin kind_next = K_FAULT; len_next = 5'd6; end
      end
      SID_ROUTINE: begin
        if (b1 < 8'd1 || b1 > 8'd3) neg_code_next = NRC_SUB_FUNC;
        else begin kind_next = K_ROUT; len_next = 5'd4; end
      end
      SID_DOWNLOAD: begin
        if (session_mode != 2'd2) neg_code_next = NRC_CONDITIONS;
        else kind_next = K_DL;
      end
      SID_TRANSFER: begin kind_next = K_XFER; len_next = 5'd2; end
      SID_EXIT:     begin kind_next = K_EXIT; len_next = 5'd1; end
      default: ;
    endcase
  end

  // response word at the current position
  assign tix = idx - 5'd3;
  always_comb begin
    cur_byte = 8'h00;
    unique case (kind)
      K_NEG: cur_byte = (idx == 5'd0) ? NEG_SID : (idx == 5'd1) ? neg_sid : neg_code;
      K_SESS: begin
        unique case (idx)
          5'd0: cur_byte = 8'h50; 5'd1: cur_byte = b1; 5'd2: cur_byte = 8'h00;
          5'd3: cur_byte = 8'h32; 5'd4: cur_byte = 8'h01;
          default: cur_byte = 8'hF4;
        endcase
      end
      K_SEED: begin
        unique case (idx)
          5'd0: cur_byte = 8'h67; 5'd1: cur_byte = 8'h01;
          5'd2: cur_byte = latched_seed[31:24]; 5'd3: cur_byte = latched_seed[23:16];
          5'd4: cur_byte = latched_seed[15:8];
          default: cur_byte = latched_seed[7:0];
        endcase
      end
      K_UNLOCK: cur_byte = (idx == 5'd0) ? 8'h67 : 8'h02;
      K_RD_VID, K_RD_VER, K_RD_SN, K_WR_OK: begin
        if (idx == 5'd0) cur_byte = (kind == K_WR_OK) ? 8'h6E : 8'h62;
        else if (idx == 5'd1) cur_byte = b1;
        else if (idx == 5'd2) cur_byte = b2;
        else if (kind == K_RD_VID) cur_byte = vid_char(tix);
        else if (kind == K_RD_VER) cur_byte = ver_char(tix);
        else begin
          for (int i = 0; i < SERIAL_BYTES; i++) begin
            if (tix == IDX_W'(i)) cur_byte = serial_store[i];
          end
        end
      end
      K_FAULT: begin
        unique case (idx)
          5'd0: cur_byte = 8'h59; 5'd1: cur_byte = 8'h02; 5'd2: cur_byte = 8'h12;
          5'd3: cur_byte = 8'h34; 5'd4: cur_byte = 8'h56;
          default: cur_byte = 8'h0F;
        endcase
      end
      K_ROUT: begin
        unique case (idx)
          5'd0: cur_byte = 8'h71; 5'd1: cur_byte = b1; 5'd2: cur_byte = b2;
          default: cur_byte = b3;
        endcase
      end
      K_DL: cur_byte = (idx == 5'd0) ? 8'h74 : (idx == 5'd1) ? 8'h20 : 8'hF0;
      K_XFER: cur_byte = (idx == 5'd0) ? 8'h76 : b1;
      K_EXIT: cur_byte = 8'h77;
      default: cur_byte = 8'h00;
    endcase
  end

  // sequencer
  always_comb begin
    state_next = state;
    pop  = 1'b0;
    load = 1'b0;
    unique case (state)
      ST_IDLE: if (nonempty) begin pop = 1'b1; state_next = ST_DECODE; end
      ST_DECODE: state_next = (len_next == '0) ? ST_IDLE : ST_EMIT;
      ST_EMIT: if (out_free) begin
        load = 1'b1;
        if (idx == len - 1'b1) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (pop) cmd <= head;
    if (state == ST_DECODE) begin
      kind     <= kind_next;
      len      <= len_next;
      neg_sid  <= neg_sid_next;
      neg_code <= neg_code_next;
      idx      <= '0;
    end else if (load) begin
      idx <= idx + 1'b1;
    end
  end

  // diagnostic state updates at decode
  always_ff @(posedge clk) begin
    if (rst) begin
      session_mode  <= 2'd1;
      unlocked_flag <= 1'b0;
      latched_seed  <= '0;
      for (int i = 0; i < SERIAL_BYTES; i++) serial_store[i] <= serial_init(i);
    end else if (state == ST_DECODE) begin
      if (kind_next == K_SESS)   session_mode  <= b1[1:0];
      if (kind_next == K_SEED)   latched_seed  <= seed_value;
      if (kind_next == K_UNLOCK) unlocked_flag <= 1'b1;
      if (kind_next == K_WR_OK)  serial_store  <= cmd.stage;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) rsp.valid <= 1'b0;
    else if (load) rsp.valid <= 1'b1;
    else if (rsp.ready) rsp.valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp.response_byte <= cur_byte;
      rsp.response_last <= (idx == len - 1'b1);
    end
  end
endmodule
`default_nettype wire
